// ===== rtl/core/tgpr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgpr_pkg
// Shared types and constants for the text glyph pixel renderer.
// ----------------------------------------------------------------------------
package tgpr_pkg;

	localparam int CELL = 8;
	localparam logic [7:0] FIRST_CODE = 8'h20;
	localparam logic [7:0] LAST_CODE  = 8'h7E;
	localparam logic [7:0] SUBST_CODE = 8'h3F;

	localparam logic [7:0] WIDTH_RESET  = 8'd160;
	localparam logic [7:0] HEIGHT_RESET = 8'd80;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_CURSOR = 2'd1,
		OP_DRAW   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		REG_SCREEN_WIDTH  = 2'd0,
		REG_SCREEN_HEIGHT = 2'd1,
		REG_COLUMN_OFFSET = 2'd2,
		REG_ROW_OFFSET    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] screen_width;
		logic [7:0] screen_height;
		logic [7:0] column_offset;
		logic [7:0] row_offset;
	} cfg_t;

	typedef struct packed {
		logic [8:0]  col;
		logic [8:0]  row;
		logic [15:0] fg;
		logic [15:0] bg;
	} draw_job_t;

endpackage
`default_nettype wire

// ===== rtl/core/tgpr_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgpr_cfg_regs
// APB register file for panel size and window offsets.
// ----------------------------------------------------------------------------
module tgpr_cfg_regs
	import tgpr_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t     cfg_q;
	cfg_reg_t reg_sel;
	logic     wr_en;

	assign pready  = 1'b1;
	assign reg_sel = cfg_reg_t'(paddr[3:2]);
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= WIDTH_RESET;
			cfg_q.screen_height <= HEIGHT_RESET;
			cfg_q.column_offset <= 8'd0;
			cfg_q.row_offset    <= 8'd0;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_SCREEN_WIDTH:  cfg_q.screen_width  <= pwdata[7:0];
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= pwdata[7:0];
				REG_COLUMN_OFFSET: cfg_q.column_offset <= pwdata[7:0];
				REG_ROW_OFFSET:    cfg_q.row_offset    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_SCREEN_WIDTH:  prdata = {24'd0, cfg_q.screen_width};
			REG_SCREEN_HEIGHT: prdata = {24'd0, cfg_q.screen_height};
			REG_COLUMN_OFFSET: prdata = {24'd0, cfg_q.column_offset};
			REG_ROW_OFFSET:    prdata = {24'd0, cfg_q.row_offset};
			default:           prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/tgpr_font_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgpr_font_store
// Glyph memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tgpr_font_store #(
	parameter int GLYPH_COUNT = 95,
	parameter int AW          = $clog2(GLYPH_COUNT)
) (
	input  wire           clk,
	input  wire           we,
	input  wire  [AW-1:0] waddr,
	input  wire  [63:0]   wdata,
	input  wire           re,
	input  wire  [AW-1:0] raddr,
	output logic [63:0]   rdata
);

	logic [63:0] mem [GLYPH_COUNT];
	logic [63:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds while no new draw is read
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/core/tgpr_cursor_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgpr_cursor_ctrl
// Cursor and halt state, wrap and bottom tests, draw job setup.
// ----------------------------------------------------------------------------
module tgpr_cursor_ctrl
	import tgpr_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         accept,
	input  wire  [1:0]  op,
	input  wire  [7:0]  start_x,
	input  wire  [7:0]  start_y,
	input  wire  [7:0]  char_code,
	input  wire  [15:0] fg_color,
	input  wire  [15:0] bg_color,
	input  cfg_t        cfg,
	output logic        draw_fire,
	output logic [6:0]  glyph_addr,
	output draw_job_t   job
);

	logic [7:0] cursor_col_q;
	logic [7:0] cursor_row_q;
	logic       halted_q;
	logic       is_draw;
	logic       wrap;
	logic       bottom_fail;
	logic [7:0] xd;
	logic [8:0] yd;
	logic [7:0] ch;

	assign is_draw = (op_t'(op) == OP_DRAW);
	assign wrap    = ({1'b0, cursor_col_q} + 9'(CELL)) > {1'b0, cfg.screen_width};
	assign xd      = wrap ? 8'd0 : cursor_col_q;
	assign yd      = wrap ? ({1'b0, cursor_row_q} + 9'(CELL)) : {1'b0, cursor_row_q};
	assign bottom_fail = (yd + 9'(CELL)) > {1'b0, cfg.screen_height};

	assign ch = (char_code < FIRST_CODE || char_code > LAST_CODE) ? SUBST_CODE : char_code;
	assign glyph_addr = 7'(ch - FIRST_CODE);

	assign draw_fire = accept & is_draw & ~halted_q & ~bottom_fail;

	assign job.col = {1'b0, xd} + {1'b0, cfg.column_offset};
	assign job.row = yd + {1'b0, cfg.row_offset};
	assign job.fg  = {fg_color[7:0], fg_color[15:8]};
	assign job.bg  = {bg_color[7:0], bg_color[15:8]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_col_q <= 8'd0;
			cursor_row_q <= 8'd0;
			halted_q     <= 1'b0;
		end else if (accept) begin
			unique case (op_t'(op))
				OP_CURSOR: begin
					cursor_col_q <= start_x;
					cursor_row_q <= start_y;
					halted_q     <= 1'b0;
				end
				OP_DRAW: begin
					if (!halted_q) begin
						// halting draw leaves the cursor where it was
						if (bottom_fail) begin
							halted_q <= 1'b1;
						end else begin
							cursor_col_q <= xd + 8'(CELL);
							cursor_row_q <= yd[7:0];
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/tgpr_pixel_ser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgpr_pixel_ser
// Holds one pending draw job and streams the 64 pixels of the active cell.
// ----------------------------------------------------------------------------
module tgpr_pixel_ser
	import tgpr_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         job_valid,
	input  draw_job_t   job,
	input  wire  [63:0] glyph,
	output logic        job_stall,
	input  wire         out_stall,
	output logic        out_valid,
	output logic [8:0]  window_col,
	output logic [8:0]  window_row,
	output logic [5:0]  pixel_index,
	output logic [15:0] pixel_word,
	output logic        last
);

	logic        valid_s1;
	draw_job_t   job_s1;
	logic        busy_q;
	draw_job_t   job_q;
	logic [63:0] glyph_q;
	logic [5:0]  cnt_q;
	logic        pix_acc;
	logic        move;

	assign last      = &cnt_q;
	assign pix_acc   = busy_q & ~out_stall;
	// pending job enters when the serializer is idle or as the last pixel of the current cell leaves
	assign move      = valid_s1 & (~busy_q | (pix_acc & last));
	assign job_stall = valid_s1 & ~move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			busy_q   <= 1'b0;
			cnt_q    <= 6'd0;
		end else begin
			if (job_valid) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (pix_acc) begin
				if (last) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid) begin
			job_s1 <= job;
		end
		if (move) begin
			job_q   <= job_s1;
			glyph_q <= glyph;
		end else if (pix_acc) begin
			glyph_q <= glyph_q >> 1;
		end
	end

	assign out_valid   = busy_q;
	assign window_col  = job_q.col;
	assign window_row  = job_q.row;
	assign pixel_index = cnt_q;
	assign pixel_word  = glyph_q[0] ? job_q.fg : job_q.bg;

`ifndef SYNTHESIS
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_acc && last && !valid_s1) |=> !busy_q)
		else $error("serializer stays busy after last pixel with no pending job");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_acc && !last) |=> (cnt_q == $past(cnt_q) + 6'd1))
		else $error("pixel count did not advance");
	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		move |=> (busy_q && cnt_q == 6'd0))
		else $error("new cell did not start at pixel zero");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/text_glyph_pixel_renderer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_glyph_pixel_renderer_core
// 8x8 text character generator: font memory, cursor control, pixel stream.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// input     in         in_valid / in_stall  op, glyph_index, glyph_bits, start_x,
//                                           start_y, char_code, fg_color, bg_color
// output    out        out_valid/out_stall  window_col, window_row, pixel_index,
//                                           pixel_word, last
// config    in         apb psel/penable     paddr, pwdata, prdata, pready
//
// a drawn character gives 64 pixels, one pixel per cycle out of the serializer while out_stall is low
// the font memory read is registered ahead of the first pixel
// one draw waits in a holding stage; in_stall rises while it cannot move on
// out_stall freezes the pixel stream; reset clears cursor and halt, not the font
// ----------------------------------------------------------------------------
module text_glyph_pixel_renderer_core
	import tgpr_pkg::*;
#(
	parameter int GLYPH_COUNT = 95
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  op,
	input  wire  [6:0]  glyph_index,
	input  wire  [63:0] glyph_bits,
	input  wire  [7:0]  start_x,
	input  wire  [7:0]  start_y,
	input  wire  [7:0]  char_code,
	input  wire  [15:0] fg_color,
	input  wire  [15:0] bg_color,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [8:0]  window_col,
	output logic [8:0]  window_row,
	output logic [5:0]  pixel_index,
	output logic [15:0] pixel_word,
	output logic        last,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(GLYPH_COUNT);

	cfg_t        cfg;
	logic        accept;
	logic        load_we;
	logic        draw_fire;
	logic [6:0]  glyph_addr;
	draw_job_t   job;
	logic [63:0] glyph_rd;
	logic        job_stall;

	assign in_stall = job_stall;
	assign accept   = in_valid & ~in_stall;
	// loads beyond the font size are dropped
	assign load_we  = accept & (op_t'(op) == OP_LOAD) &
		(9'(glyph_index) < 9'(GLYPH_COUNT));

	tgpr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tgpr_font_store #(
		.GLYPH_COUNT (GLYPH_COUNT),
		.AW          (AW)
	) u_font (
		.clk   (clk),
		.we    (load_we),
		.waddr (AW'(glyph_index)),
		.wdata (glyph_bits),
		.re    (draw_fire),
		.raddr (AW'(glyph_addr)),
		.rdata (glyph_rd)
	);

	tgpr_cursor_ctrl u_cursor (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.op         (op),
		.start_x    (start_x),
		.start_y    (start_y),
		.char_code  (char_code),
		.fg_color   (fg_color),
		.bg_color   (bg_color),
		.cfg        (cfg),
		.draw_fire  (draw_fire),
		.glyph_addr (glyph_addr),
		.job        (job)
	);

	tgpr_pixel_ser u_ser (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (draw_fire),
		.job         (job),
		.glyph       (glyph_rd),
		.job_stall   (job_stall),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.window_col  (window_col),
		.window_row  (window_row),
		.pixel_index (pixel_index),
		.pixel_word  (pixel_word),
		.last        (last)
	);

endmodule
`default_nettype wire

// ===== sim/text_glyph_pixel_renderer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_glyph_pixel_renderer_core_tb
// Loads a font, then sends cursor, draw and load transactions: directed edge
// and halt cases first, then random strings under several panel settings and
// with random sender gaps and receiver stalls. Each pixel is checked against
// a shadow cursor and font.
// ----------------------------------------------------------------------------
module text_glyph_pixel_renderer_core_tb;
	import tgpr_pkg::*;

	localparam int GLYPHS = 95;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_PRINTS = 40;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [6:0]  glyph_index;
		logic [63:0] glyph_bits;
		logic [7:0]  start_x;
		logic [7:0]  start_y;
		logic [7:0]  char_code;
		logic [15:0] fg_color;
		logic [15:0] bg_color;
	} char_item_t;

	typedef struct packed {
		logic [8:0]  col;
		logic [8:0]  row;
		logic [5:0]  pix_idx;
		logic [15:0] word;
		logic        last;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  op = OP_LOAD;
	logic [6:0]  glyph_index = '0;
	logic [63:0] glyph_bits = '0;
	logic [7:0]  start_x = '0;
	logic [7:0]  start_y = '0;
	logic [7:0]  char_code = '0;
	logic [15:0] fg_color = '0;
	logic [15:0] bg_color = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [8:0]  window_col;
	logic [8:0]  window_row;
	logic [5:0]  pixel_index;
	logic [15:0] pixel_word;
	logic        last;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	text_glyph_pixel_renderer_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.glyph_index (glyph_index),
		.glyph_bits  (glyph_bits),
		.start_x     (start_x),
		.start_y     (start_y),
		.char_code   (char_code),
		.fg_color    (fg_color),
		.bg_color    (bg_color),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.window_col  (window_col),
		.window_row  (window_row),
		.pixel_index (pixel_index),
		.pixel_word  (pixel_word),
		.last        (last),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always #10 clk = ~clk;

	// shadow of the block state
	logic [63:0] font_shadow [GLYPHS];
	logic [7:0]  cursor_col = '0;
	logic [7:0]  cursor_row = '0;
	logic        halted = 1'b0;
	cfg_t        panel = '{WIDTH_RESET, HEIGHT_RESET, 8'd0, 8'd0};
	pixel_t      pixel_q [$];
	int          errors = 0;
	int          sender_idle_pct = 0;
	int          recv_stall_pct = 0;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		errors++;
		// keep the log short when a bug hits every pixel
		if (errors <= MAX_PRINTS)
			$display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	function automatic logic [15:0] swap16(input logic [15:0] c);
		return {c[7:0], c[15:8]};
	endfunction

	task automatic predict_pixels(input char_item_t it);
		logic [7:0]  code;
		logic [8:0]  x;
		logic [8:0]  y;
		logic [63:0] glyph;
		pixel_t      px;
		case (it.op)
			OP_LOAD: begin
				if (it.glyph_index < GLYPHS)
					font_shadow[it.glyph_index] = it.glyph_bits;
			end
			OP_CURSOR: begin
				cursor_col = it.start_x;
				cursor_row = it.start_y;
				halted = 1'b0;
			end
			OP_DRAW: begin
				if (!halted) begin
					code = it.char_code;
					if (code < FIRST_CODE || code > LAST_CODE)
						code = SUBST_CODE;
					glyph = font_shadow[code - FIRST_CODE];
					x = {1'b0, cursor_col};
					y = {1'b0, cursor_row};
					if (x + CELL > panel.screen_width) begin
						x = '0;
						y = 9'(y + CELL);
					end
					if (y + CELL > panel.screen_height) begin
						halted = 1'b1;
					end else begin
						for (int p = 0; p < 64; p++) begin
							px.col = 9'(x + panel.column_offset);
							px.row = 9'(y + panel.row_offset);
							px.pix_idx = 6'(p);
							px.word = glyph[p] ? swap16(it.fg_color) : swap16(it.bg_color);
							px.last = (p == 63);
							pixel_q.push_back(px);
						end
						cursor_col = 8'(x + CELL);
						cursor_row = y[7:0];
					end
				end
			end
			default: ;
		endcase
	endtask

	// pixel checker
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pixel_q.size() == 0) begin
				report_mismatch("pixel with nothing expected", {window_col, window_row,
					pixel_index, pixel_word, last}, '0);
			end else begin
				want = pixel_q.pop_front();
				if (window_col !== want.col)
					report_mismatch("window_col", window_col, want.col);
				if (window_row !== want.row)
					report_mismatch("window_row", window_row, want.row);
				if (pixel_index !== want.pix_idx)
					report_mismatch("pixel_index", pixel_index, want.pix_idx);
				if (pixel_word !== want.word)
					report_mismatch("pixel_word", pixel_word, want.word);
				if (last !== want.last)
					report_mismatch("last", last, want.last);
			end
		end
	end

	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

	task automatic send_item(input char_item_t it);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= it.op;
		glyph_index <= it.glyph_index;
		glyph_bits <= it.glyph_bits;
		start_x <= it.start_x;
		start_y <= it.start_y;
		char_code <= it.char_code;
		fg_color <= it.fg_color;
		bg_color <= it.bg_color;
		do @(posedge clk); while (in_stall);
		predict_pixels(it);
	endtask

	function automatic char_item_t noise_item();
		char_item_t it;
		it.op = OP_UNUSED;
		it.glyph_index = 7'($urandom);
		it.glyph_bits = {$urandom, $urandom};
		it.start_x = 8'($urandom);
		it.start_y = 8'($urandom);
		it.char_code = 8'($urandom);
		it.fg_color = 16'($urandom);
		it.bg_color = 16'($urandom);
		return it;
	endfunction

	function automatic char_item_t load_item(input logic [6:0] idx, input logic [63:0] bits);
		char_item_t it;
		it = noise_item();
		it.op = OP_LOAD;
		it.glyph_index = idx;
		it.glyph_bits = bits;
		return it;
	endfunction

	function automatic char_item_t cursor_item(input logic [7:0] x, input logic [7:0] y);
		char_item_t it;
		it = noise_item();
		it.op = OP_CURSOR;
		it.start_x = x;
		it.start_y = y;
		return it;
	endfunction

	function automatic char_item_t draw_item(input logic [7:0] code, input logic [15:0] fg,
			input logic [15:0] bg);
		char_item_t it;
		it = noise_item();
		it.op = OP_DRAW;
		it.char_code = code;
		it.fg_color = fg;
		it.bg_color = bg;
		return it;
	endfunction

	function automatic logic [7:0] random_code();
		if ($urandom_range(0, 99) < 15)
			return 8'($urandom);
		return 8'($urandom_range(FIRST_CODE, LAST_CODE));
	endfunction

	// registers are only touched once the pixel stream has gone quiet
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_xfer(input logic wr, input cfg_reg_t r, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {r, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_register(input cfg_reg_t r, input logic [7:0] v);
		logic [31:0] wdata;
		logic [31:0] rd;
		wdata = $urandom;
		wdata[7:0] = v;
		apb_xfer(1'b1, r, wdata, rd);
		case (r)
			REG_SCREEN_WIDTH:  panel.screen_width = v;
			REG_SCREEN_HEIGHT: panel.screen_height = v;
			REG_COLUMN_OFFSET: panel.column_offset = v;
			REG_ROW_OFFSET:    panel.row_offset = v;
			default: ;
		endcase
		apb_xfer(1'b0, r, 32'h0, rd);
		if (rd[7:0] !== v)
			report_mismatch("register readback", rd, v);
	endtask

	task automatic set_panel(input logic [7:0] w, input logic [7:0] h, input logic [7:0] co,
			input logic [7:0] ro);
		wait_drained();
		set_register(REG_SCREEN_WIDTH, w);
		set_register(REG_SCREEN_HEIGHT, h);
		set_register(REG_COLUMN_OFFSET, co);
		set_register(REG_ROW_OFFSET, ro);
	endtask

	task automatic test_font_load();
		logic [63:0] bits;
		for (int i = 0; i < GLYPHS; i++) begin
			bits = {$urandom, $urandom};
			// space blank, '!' solid
			if (i == 0)
				bits = '0;
			else if (i == 1)
				bits = '1;
			send_item(load_item(7'(i), bits));
		end
		// indexes past the font are dropped
		send_item(load_item(7'(GLYPHS), '1));
		send_item(load_item(7'h7F, '1));
	endtask

	task automatic test_directed_draws();
		send_item(cursor_item(8'd0, 8'd0));
		send_item(draw_item(8'h20, 16'hFFFF, 16'h0000));
		send_item(draw_item(8'h21, 16'h00FF, 16'hFF00));
		send_item(draw_item(8'h7E, 16'h1234, 16'hABCD));
		// codes outside the printable range fall back to '?'
		send_item(draw_item(8'h00, 16'hF00F, 16'h0FF0));
		send_item(draw_item(8'hFF, 16'h5A5A, 16'hA5A5));
		send_item(draw_item(8'h1F, 16'hFFFF, 16'h0000));
		send_item(draw_item(8'h7F, 16'h0000, 16'hFFFF));
		// right edge wrap
		send_item(cursor_item(8'd156, 8'd0));
		send_item(draw_item("A", 16'h1111, 16'h2222));
		// last cell that fits, then wrap past the bottom halts
		send_item(cursor_item(8'd152, 8'd72));
		send_item(draw_item("B", 16'h3333, 16'h4444));
		send_item(draw_item("C", 16'h5555, 16'h6666));
		send_item(draw_item("D", 16'h7777, 16'h8888));
		send_item(load_item(7'h22, {$urandom, $urandom}));
		send_item(noise_item());
		send_item(cursor_item(8'd255, 8'd255));
		send_item(draw_item("E", 16'h9999, 16'hAAAA));
		send_item(cursor_item(8'd8, 8'd16));
		send_item(draw_item(8'h42, 16'hBBBB, 16'hCCCC));
	endtask

	task automatic test_register_extremes();
		set_panel(8'd8, 8'd8, 8'd255, 8'd255);
		send_item(cursor_item(8'd0, 8'd0));
		send_item(draw_item("F", 16'hFFFF, 16'h0000));
		send_item(draw_item("G", 16'h0000, 16'hFFFF));
		send_item(cursor_item(8'd7, 8'd0));
		send_item(draw_item("H", 16'h1357, 16'h2468));
		send_item(cursor_item(8'd0, 8'd0));
		send_item(draw_item("I", 16'h8642, 16'h7531));
		set_panel(8'd255, 8'd255, 8'd0, 8'd0);
		send_item(cursor_item(8'd247, 8'd247));
		send_item(draw_item("J", 16'hFEDC, 16'h0123));
		send_item(draw_item("K", 16'h0123, 16'hFEDC));
		send_item(cursor_item(8'd248, 8'd0));
		send_item(draw_item("L", 16'hC0DE, 16'hFACE));
		set_panel(8'd255, 8'd255, 8'd255, 8'd255);
		send_item(cursor_item(8'd247, 8'd247));
		send_item(draw_item("M", 16'hFFFF, 16'h0000));
	endtask

	task automatic run_random(input int n);
		int sent;
		int r;
		int k;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				send_item(cursor_item(8'($urandom_range(0, panel.screen_width - 1)),
					8'($urandom_range(0, panel.screen_height - 1))));
				k = $urandom_range(1, 5);
				repeat (k)
					send_item(draw_item(random_code(), 16'($urandom), 16'($urandom)));
				sent += k + 1;
			end else if (r < 77) begin
				send_item(load_item(7'($urandom), {$urandom, $urandom}));
				sent++;
			end else if (r < 87) begin
				send_item(draw_item(random_code(), 16'($urandom), 16'($urandom)));
				sent++;
			end else if (r < 94) begin
				send_item(cursor_item(8'($urandom), 8'($urandom)));
				sent++;
			end else begin
				send_item(noise_item());
			end
		end
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
		set_panel(8'($urandom_range(16, 255)), 8'($urandom_range(16, 255)),
			8'($urandom), 8'($urandom));
		sender_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		run_random(n);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_font_load();
		test_directed_draws();
		test_register_extremes();
		test_random_traffic(0, 0, 15);
		test_random_traffic(69, 0, 15);
		test_random_traffic(0, 69, 15);
		test_random_traffic(15, 15, 15);
		wait_drained();
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
